// ----- hw/rtl/kpl_pkg.sv -----
// ----------------------------------------------------------------------------
// kpl_pkg
// shared types, constants and trig tables for the per-angle kalman plotter
// ----------------------------------------------------------------------------
`default_nettype none

package kpl_pkg;

  localparam int NUM_ANGLES   = 360;
  localparam int ANGLE_W      = 9;
  localparam int RANGE_W      = 16;
  localparam int UNC_W        = 17;
  localparam int SIN_W        = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int RESULT_DEPTH = 2;

  localparam logic [UNC_W-1:0]   UNC_ONE         = 17'h10000;
  localparam logic [RANGE_W-1:0] LIMIT_RESET     = 16'd15360;
  localparam logic [RANGE_W-1:0] OFFSET_RESET    = 16'd512;
  localparam logic [RANGE_W-1:0] NOISE_RESET     = 16'd256;
  localparam logic signed [21:0] SCREEN_CENTER   = 22'sd6400;

  typedef enum logic [1:0] {
    REG_LIMIT  = 2'd0,
    REG_OFFSET = 2'd1,
    REG_NOISE  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_deg;
    logic [RANGE_W-1:0] range_sample;
  } sample_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        point_angle;
    logic [RANGE_W-1:0]        filtered_range;
    logic signed [RANGE_W-1:0] screen_x;
    logic signed [RANGE_W-1:0] screen_y;
  } result_t;

  typedef struct packed {
    logic [UNC_W-1:0]   unc;
    logic [RANGE_W-1:0] est;
  } filt_entry_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_LOAD,
    B_DIV,
    B_UPDATE,
    B_WRITE,
    B_PLOT,
    B_EMIT
  } back_state_t;

  // sin(k deg) for k in 0..90, q1.14
  function automatic logic [14:0] quarter_sin(input logic [6:0] k);
    logic [14:0] v;
    unique case (k)
      7'd0:  v = 15'd0;     7'd1:  v = 15'd286;   7'd2:  v = 15'd572;
      7'd3:  v = 15'd857;   7'd4:  v = 15'd1143;  7'd5:  v = 15'd1428;
      7'd6:  v = 15'd1713;  7'd7:  v = 15'd1997;  7'd8:  v = 15'd2280;
      7'd9:  v = 15'd2563;  7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
      7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
      7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
      7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
      7'd21: v = 15'd5872;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
      7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
      7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
      7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
      7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
      7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
      7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
      7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
      7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
      7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
      7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
      7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
      7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
      7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
      7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
      7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
      7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
      7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
      7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
      7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
      7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
      7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
      7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
      7'd90: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // sin(a deg) for a in 0..359, signed q1.14, by quadrant symmetry
  function automatic logic signed [SIN_W-1:0] sin_deg(input logic [ANGLE_W-1:0] a);
    logic [14:0] q;
    logic        neg;
    if (a >= 9'd270) begin
      q   = quarter_sin(7'(9'd360 - a));
      neg = 1'b1;
    end else if (a >= 9'd180) begin
      q   = quarter_sin(7'(a - 9'd180));
      neg = 1'b1;
    end else if (a >= 9'd90) begin
      q   = quarter_sin(7'(9'd180 - a));
      neg = 1'b0;
    end else begin
      q   = quarter_sin(a[6:0]);
      neg = 1'b0;
    end
    return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kpl_fifo.sv -----
// ----------------------------------------------------------------------------
// kpl_fifo
// small register queue with full/empty flags, show-ahead read
// ----------------------------------------------------------------------------
`default_nettype none

module kpl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/kpl_front.sv -----
// ----------------------------------------------------------------------------
// kpl_front
// sample intake: drops out-of-range samples, queues the rest for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module kpl_front #(
  parameter int QUEUE_DEPTH = kpl_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire kpl_pkg::sample_t              sample,
  output logic                               full,
  input  wire logic                          hold,
  input  wire logic [kpl_pkg::RANGE_W-1:0]   range_limit,
  output logic                               q_valid,
  output kpl_pkg::sample_t                   q_item,
  input  wire logic                          q_pop
);

  logic accept;
  logic keep;
  logic q_full;
  logic q_empty;

  assign full    = q_full || hold;
  assign accept  = push && !full;
  assign keep    = (sample.angle_deg < kpl_pkg::ANGLE_W'(kpl_pkg::NUM_ANGLES)) &&
                   (sample.range_sample <= range_limit);
  assign q_valid = !q_empty;

  kpl_fifo #(
    .WIDTH ($bits(kpl_pkg::sample_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept && keep),
    .wr_data (sample),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_item),
    .empty   (q_empty)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/kpl_back.sv -----
// ----------------------------------------------------------------------------
// kpl_back
// filter store, gain divider, kalman update and screen projection
// ----------------------------------------------------------------------------
`default_nettype none

module kpl_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_valid,
  input  wire kpl_pkg::sample_t                  q_item,
  output logic                                   q_pop,
  output logic                                   clearing,
  input  wire logic signed [kpl_pkg::RANGE_W-1:0] range_offset,
  input  wire logic [kpl_pkg::RANGE_W-1:0]       measurement_noise,
  output logic                                   res_push,
  output kpl_pkg::result_t                       res_item,
  input  wire logic                              res_full
);

  localparam int ADDR_W = $clog2(kpl_pkg::NUM_ANGLES);
  localparam int DEN_W  = kpl_pkg::RANGE_W + 9;
  localparam int REM_W  = DEN_W + 1;
  localparam int CNT_W  = $clog2(kpl_pkg::UNC_W + 1);

  kpl_pkg::back_state_t state, state_next;

  kpl_pkg::filt_entry_t mem [kpl_pkg::NUM_ANGLES];
  kpl_pkg::filt_entry_t rd_data;
  kpl_pkg::filt_entry_t wr_entry;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_addr;
  logic [ADDR_W-1:0]    clr_cnt;

  logic [ADDR_W-1:0]                  angle;
  logic [kpl_pkg::RANGE_W-1:0]        meas;
  logic [kpl_pkg::RANGE_W-1:0]        est;
  logic [kpl_pkg::UNC_W-1:0]          unc;
  logic [DEN_W-1:0]                   den;
  logic                               den_zero;
  logic [REM_W-1:0]                   rem;
  logic [kpl_pkg::UNC_W-1:0]          gain;
  logic [CNT_W-1:0]                   div_cnt;
  logic signed [34:0]                 prod_e;
  logic [33:0]                        prod_u;
  logic signed [17:0]                 plot_range;
  logic signed [kpl_pkg::SIN_W-1:0]   sin_x;
  logic signed [kpl_pkg::SIN_W-1:0]   sin_y;
  logic signed [36:0]                 px;
  logic signed [36:0]                 py;

  logic [kpl_pkg::UNC_W-1:0]          unc_rd;
  logic [DEN_W-1:0]                   den_ld;
  logic                               div_ge;
  logic [kpl_pkg::UNC_W-1:0]          gain_eff;
  logic signed [16:0]                 diff;
  logic [kpl_pkg::RANGE_W-1:0]        est_new;
  logic [kpl_pkg::UNC_W-1:0]          unc_new;
  logic [ADDR_W-1:0]                  cos_angle;
  logic signed [20:0]                 dist_ext;
  logic signed [20:0]                 dist5;
  logic signed [21:0]                 vx;
  logic signed [21:0]                 vy;

  assign clearing = (state == kpl_pkg::B_CLEAR);

  // store: clearing pass writes the reset entry, write-back writes the update
  always_comb begin
    unc_new  = prod_u[32:16];
    est_new  = est + prod_e[31:16];
    mem_we   = (state == kpl_pkg::B_CLEAR) || (state == kpl_pkg::B_WRITE);
    mem_addr = clearing ? clr_cnt : angle;
    wr_entry.unc = clearing ? kpl_pkg::UNC_ONE : unc_new;
    wr_entry.est = clearing ? '0 : est_new;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wr_entry;
    end
    rd_data <= mem[angle];
  end

  always_comb begin
    unc_rd    = (rd_data.unc > kpl_pkg::UNC_ONE) ? kpl_pkg::UNC_ONE : rd_data.unc;
    den_ld    = DEN_W'(unc_rd) + {measurement_noise, 8'd0} ;
    div_ge    = (rem >= REM_W'(den));
    gain_eff  = den_zero ? '0 : gain;
    diff      = $signed({1'b0, meas}) - $signed({1'b0, est});
    cos_angle = (angle >= ADDR_W'(270)) ? ADDR_W'(angle - ADDR_W'(270))
                                        : ADDR_W'(angle + ADDR_W'(90));
    dist_ext  = {{3{plot_range[17]}}, plot_range};
    dist5     = (dist_ext <<< 2) + dist_ext;
    vx        = kpl_pkg::SCREEN_CENTER - {{3{px[36]}}, px[36:18]};
    vy        = kpl_pkg::SCREEN_CENTER - {{3{py[36]}}, py[36:18]};
  end

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    logic signed [15:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    res_item.point_angle    = angle;
    res_item.filtered_range = est;
    res_item.screen_x       = sat16(vx);
    res_item.screen_y       = sat16(vy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= kpl_pkg::B_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    res_push   = 1'b0;
    unique case (state)
      kpl_pkg::B_CLEAR: begin
        if (clr_cnt == ADDR_W'(kpl_pkg::NUM_ANGLES - 1)) begin
          state_next = kpl_pkg::B_IDLE;
        end
      end
      kpl_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = kpl_pkg::B_READ;
        end
      end
      kpl_pkg::B_READ:   state_next = kpl_pkg::B_LOAD;
      kpl_pkg::B_LOAD:   state_next = kpl_pkg::B_DIV;
      kpl_pkg::B_DIV: begin
        if (div_cnt == CNT_W'(1)) begin
          state_next = kpl_pkg::B_UPDATE;
        end
      end
      kpl_pkg::B_UPDATE: state_next = kpl_pkg::B_WRITE;
      kpl_pkg::B_WRITE:  state_next = kpl_pkg::B_PLOT;
      kpl_pkg::B_PLOT:   state_next = kpl_pkg::B_EMIT;
      kpl_pkg::B_EMIT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = kpl_pkg::B_IDLE;
        end
      end
      default: state_next = kpl_pkg::B_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      kpl_pkg::B_IDLE: begin
        angle <= q_item.angle_deg;
        meas  <= q_item.range_sample;
      end
      kpl_pkg::B_LOAD: begin
        est      <= rd_data.est;
        unc      <= unc_rd;
        den      <= den_ld;
        den_zero <= (den_ld == '0);
        rem      <= REM_W'(unc_rd);
        gain     <= '0;
        div_cnt  <= CNT_W'(kpl_pkg::UNC_W);
      end
      kpl_pkg::B_DIV: begin
        gain    <= {gain[kpl_pkg::UNC_W-2:0], div_ge};
        rem     <= (div_ge ? rem - REM_W'(den) : rem) << 1;
        div_cnt <= div_cnt - 1'b1;
      end
      kpl_pkg::B_UPDATE: begin
        prod_e <= $signed({1'b0, gain_eff}) * diff;
        prod_u <= (kpl_pkg::UNC_ONE - gain_eff) * unc;
      end
      kpl_pkg::B_WRITE: begin
        est        <= est_new;
        plot_range <= $signed({2'b00, est_new}) +
                      $signed({{2{range_offset[15]}}, range_offset});
        sin_x      <= kpl_pkg::sin_deg(angle);
        sin_y      <= kpl_pkg::sin_deg(cos_angle);
      end
      kpl_pkg::B_PLOT: begin
        px <= dist5 * sin_x;
        py <= dist5 * sin_y;
      end
      default: begin
      end
    endcase
  end

  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == kpl_pkg::B_UPDATE && !den_zero) |-> (gain <= kpl_pkg::UNC_ONE))
    else $error("gain above one");

  a_unc_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == kpl_pkg::B_WRITE) |-> (unc_new <= kpl_pkg::UNC_ONE))
    else $error("uncertainty above one on write-back");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop)
    else $error("queue popped during clearing pass");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (state == kpl_pkg::B_IDLE))
    else $error("no return to idle after result");

endmodule

`default_nettype wire

// ----- hw/rtl/lidar_per_angle_kalman_plotter_unit.sv -----
// ----------------------------------------------------------------------------
// lidar_per_angle_kalman_plotter_unit
// per-angle scalar kalman filter for lidar samples with screen projection
// ----------------------------------------------------------------------------
// each sample request carries an angle in whole degrees and a q8.8 distance.
// samples with an angle past 359 or a distance above range_limit are
// dropped and give no result. every other sample runs one kalman update on
// its angle's filter (estimate q8.8, uncertainty q1.16) with gain
// u/(u + r) from a 17-step restoring divider, then projects the estimate plus
// range_offset to screen x/y in signed q12.4, saturated. one result per
// kept sample, in order. in the back end a kept sample goes through queue
// pop, store read and load, 17 divider steps, update, write-back, plot and
// emit, which waits while the result queue is full. a dropped sample is
// discarded at intake. the front queue keeps taking samples while the back
// end works. after reset the filter store is cleared one angle per cycle,
// all 360 angles, during which full stays high; register writes are taken
// at any time and should only be made while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_per_angle_kalman_plotter_unit #(
  parameter int QUEUE_DEPTH  = kpl_pkg::QUEUE_DEPTH,
  parameter int RESULT_DEPTH = kpl_pkg::RESULT_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // sample side
  input  wire logic                        push,
  input  wire kpl_pkg::sample_t            sample,
  output logic                             full,
  // result side
  output logic                             empty,
  input  wire logic                        pop,
  output kpl_pkg::result_t                 result,
  // register writes
  input  wire logic                        cfg_write,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [kpl_pkg::RANGE_W-1:0] cfg_data
);

  // configuration registers
  logic [kpl_pkg::RANGE_W-1:0]        range_limit;
  logic signed [kpl_pkg::RANGE_W-1:0] range_offset;
  logic [kpl_pkg::RANGE_W-1:0]        measurement_noise;

  // front to back queue
  logic             q_valid;
  logic             q_pop;
  kpl_pkg::sample_t q_item;
  logic             clearing;

  // back end to result queue
  logic             res_push;
  logic             res_full;
  kpl_pkg::result_t res_item;

  // index past the list falls through and is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit       <= kpl_pkg::LIMIT_RESET;
      range_offset      <= kpl_pkg::OFFSET_RESET;
      measurement_noise <= kpl_pkg::NOISE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        kpl_pkg::REG_LIMIT:  range_limit       <= cfg_data;
        kpl_pkg::REG_OFFSET: range_offset      <= cfg_data;
        kpl_pkg::REG_NOISE:  measurement_noise <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // intake: classify and queue; held off while the store is being cleared
  kpl_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .sample      (sample),
    .full        (full),
    .hold        (clearing),
    .range_limit (range_limit),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  // filter update and projection
  kpl_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .range_offset      (range_offset),
    .measurement_noise (measurement_noise),
    .res_push          (res_push),
    .res_item          (res_item),
    .res_full          (res_full)
  );

  // result queue decouples the back end from the consumer
  kpl_fifo #(
    .WIDTH ($bits(kpl_pkg::result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_results (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .rd      (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

`default_nettype wire
